// ----- rtl/sec_pkg.sv -----
// sec_pkg: shared widths, flag bit positions, item/control types and the
// position-width helper for the swept edge collision unit.
// No dependencies; compile first.
package sec_pkg;

  localparam int FRAC_BITS = 8;

  localparam int FLAGS_W  = 6;
  localparam int ORIGIN_W = 16;
  localparam int SPEED_W  = 16;
  localparam int LEN_W    = 12;
  localparam int STEP_W   = 10;
  localparam int PUSH_W   = 20;

  // edge_flags bit positions
  localparam int FLG_ORIENT1 = 0;
  localparam int FLG_ORIENT2 = 1;
  localparam int FLG_POS1    = 2;
  localparam int FLG_NEG1    = 3;
  localparam int FLG_POS2    = 4;
  localparam int FLG_NEG2    = 5;

  localparam logic signed [PUSH_W-1:0] PUSH_MAX = {1'b0, {(PUSH_W-1){1'b1}}};
  localparam logic signed [PUSH_W-1:0] PUSH_MIN = {1'b1, {(PUSH_W-1){1'b0}}};

  typedef struct packed {
    logic        [FLAGS_W-1:0]  edge_flags;
    logic signed [ORIGIN_W-1:0] first_origin_x;
    logic signed [ORIGIN_W-1:0] first_origin_y;
    logic signed [SPEED_W-1:0]  first_speed_x;
    logic signed [SPEED_W-1:0]  first_speed_y;
    logic        [LEN_W-1:0]    first_length;
    logic signed [ORIGIN_W-1:0] second_origin_x;
    logic signed [ORIGIN_W-1:0] second_origin_y;
    logic signed [SPEED_W-1:0]  second_speed_x;
    logic signed [SPEED_W-1:0]  second_speed_y;
    logic        [LEN_W-1:0]    second_length;
    logic        [STEP_W-1:0]   step_ms;
  } sec_item_t;

  // control from the motion stage to the resolve logic
  typedef struct packed {
    logic orient_y;  // first edge is a Y edge
    logic active;    // same orientation and approaching per the direction flags
    logic old_le;    // old first position <= old second position
    logic old_ge;    // old first position >= old second position
  } sec_ctrl_t;

  // Fixed-point position width: scaled origin or speed*time, plus room for
  // the sum and for the added scaled length.
  function automatic int pos_width(int frac);
    int base;
    base = ORIGIN_W + frac;
    if (base < SPEED_W + STEP_W + 1) base = SPEED_W + STEP_W + 1;
    return base + 2;
  endfunction

endpackage

// ----- rtl/sec_in_if.sv -----
// sec_in_if: input channel of the swept edge collision unit (valid/ready
// plus one edge-pair word). Depends on sec_pkg.
interface sec_in_if;
  logic                                valid;
  logic                                ready;
  logic        [sec_pkg::FLAGS_W-1:0]  edge_flags;
  logic signed [sec_pkg::ORIGIN_W-1:0] first_origin_x;
  logic signed [sec_pkg::ORIGIN_W-1:0] first_origin_y;
  logic signed [sec_pkg::SPEED_W-1:0]  first_speed_x;
  logic signed [sec_pkg::SPEED_W-1:0]  first_speed_y;
  logic        [sec_pkg::LEN_W-1:0]    first_length;
  logic signed [sec_pkg::ORIGIN_W-1:0] second_origin_x;
  logic signed [sec_pkg::ORIGIN_W-1:0] second_origin_y;
  logic signed [sec_pkg::SPEED_W-1:0]  second_speed_x;
  logic signed [sec_pkg::SPEED_W-1:0]  second_speed_y;
  logic        [sec_pkg::LEN_W-1:0]    second_length;
  logic        [sec_pkg::STEP_W-1:0]   step_ms;

  modport source (
    output valid, edge_flags, first_origin_x, first_origin_y, first_speed_x,
           first_speed_y, first_length, second_origin_x, second_origin_y,
           second_speed_x, second_speed_y, second_length, step_ms,
    input  ready
  );

  modport sink (
    input  valid, edge_flags, first_origin_x, first_origin_y, first_speed_x,
           first_speed_y, first_length, second_origin_x, second_origin_y,
           second_speed_x, second_speed_y, second_length, step_ms,
    output ready
  );
endinterface

// ----- rtl/sec_out_if.sv -----
// sec_out_if: result channel of the swept edge collision unit (valid/ready
// plus the push word). Depends on sec_pkg.
interface sec_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [sec_pkg::PUSH_W-1:0] push_x;
  logic signed [sec_pkg::PUSH_W-1:0] push_y;

  modport source (output valid, push_x, push_y, input ready);
  modport sink (input valid, push_x, push_y, output ready);
endinterface

// ----- rtl/sec_motion.sv -----
// sec_motion: axis selection, approach test and swept positions
// (origin*scale + speed*step) for both edges. Depends on sec_pkg.
module sec_motion #(
  parameter int  FRAC_BITS = sec_pkg::FRAC_BITS,
  localparam int POS_W     = sec_pkg::pos_width(FRAC_BITS)
) (
  input  sec_pkg::sec_item_t       item,
  output sec_pkg::sec_ctrl_t       ctrl,
  output logic signed [POS_W-1:0]  a1n,
  output logic signed [POS_W-1:0]  a2n,
  output logic signed [POS_W-1:0]  b1,
  output logic signed [POS_W-1:0]  b2,
  output logic signed [POS_W-1:0]  e1,
  output logic signed [POS_W-1:0]  e2
);
  localparam int PROD_W = sec_pkg::SPEED_W + sec_pkg::STEP_W + 1;

  logic o1, o2, p1, n1, p2, n2, approach;
  logic signed [sec_pkg::ORIGIN_W-1:0] a1, a2, s1, s2;
  logic signed [sec_pkg::SPEED_W-1:0]  va1, va2, vs1, vs2;
  logic signed [sec_pkg::SPEED_W:0]    v;
  logic signed [sec_pkg::STEP_W:0]     ms_s;
  logic signed [PROD_W-1:0]            pa1, pa2, ps1, ps2;

  assign o1 = item.edge_flags[sec_pkg::FLG_ORIENT1];
  assign o2 = item.edge_flags[sec_pkg::FLG_ORIENT2];
  assign p1 = item.edge_flags[sec_pkg::FLG_POS1];
  assign n1 = item.edge_flags[sec_pkg::FLG_NEG1];
  assign p2 = item.edge_flags[sec_pkg::FLG_POS2];
  assign n2 = item.edge_flags[sec_pkg::FLG_NEG2];

  // motion axis follows the first edge's orientation
  assign a1  = o1 ? item.first_origin_y  : item.first_origin_x;
  assign a2  = o1 ? item.second_origin_y : item.second_origin_x;
  assign s1  = o1 ? item.first_origin_x  : item.first_origin_y;
  assign s2  = o1 ? item.second_origin_x : item.second_origin_y;
  assign va1 = o1 ? item.first_speed_y   : item.first_speed_x;
  assign va2 = o1 ? item.second_speed_y  : item.second_speed_x;
  assign vs1 = o1 ? item.first_speed_x   : item.first_speed_y;
  assign vs2 = o1 ? item.second_speed_x  : item.second_speed_y;

  assign v = (sec_pkg::SPEED_W+1)'(va1) - (sec_pkg::SPEED_W+1)'(va2);
  assign approach = (p1 && n2 && !v[sec_pkg::SPEED_W]) ||
                    (n1 && p2 && (v[sec_pkg::SPEED_W] || v == '0));

  assign ms_s = $signed({1'b0, item.step_ms});
  assign pa1  = va1 * ms_s;
  assign pa2  = va2 * ms_s;
  assign ps1  = vs1 * ms_s;
  assign ps2  = vs2 * ms_s;

  assign a1n = (POS_W'(a1) <<< FRAC_BITS) + POS_W'(pa1);
  assign a2n = (POS_W'(a2) <<< FRAC_BITS) + POS_W'(pa2);
  assign b1  = (POS_W'(s1) <<< FRAC_BITS) + POS_W'(ps1);
  assign b2  = (POS_W'(s2) <<< FRAC_BITS) + POS_W'(ps2);
  assign e1  = b1 + ($signed(POS_W'(item.first_length)) <<< FRAC_BITS);
  assign e2  = b2 + ($signed(POS_W'(item.second_length)) <<< FRAC_BITS);

  assign ctrl.orient_y = o1;
  assign ctrl.active   = (o1 == o2) && approach;
  assign ctrl.old_le   = (a1 <= a2);
  assign ctrl.old_ge   = (a1 >= a2);
endmodule

// ----- rtl/sec_resolve.sv -----
// sec_resolve: extent overlap, crossing test, round-away-from-zero,
// saturation and routing onto push_x/push_y. Depends on sec_pkg.
module sec_resolve #(
  parameter int  FRAC_BITS = sec_pkg::FRAC_BITS,
  localparam int POS_W     = sec_pkg::pos_width(FRAC_BITS)
) (
  input  sec_pkg::sec_ctrl_t                  ctrl,
  input  logic signed [POS_W-1:0]             a1n,
  input  logic signed [POS_W-1:0]             a2n,
  input  logic signed [POS_W-1:0]             b1,
  input  logic signed [POS_W-1:0]             b2,
  input  logic signed [POS_W-1:0]             e1,
  input  logic signed [POS_W-1:0]             e2,
  output logic signed [sec_pkg::PUSH_W-1:0]   push_x,
  output logic signed [sec_pkg::PUSH_W-1:0]   push_y
);
  localparam int RND_W = POS_W + 2;
  localparam int BIAS  = (1 << FRAC_BITS) - 1;

  logic overlap, crossed, fits;
  logic signed [RND_W-1:0] d, r;
  logic [RND_W-sec_pkg::PUSH_W:0] upper;
  logic signed [sec_pkg::PUSH_W-1:0] sat, delta;

  assign overlap = (b1 <= b2 && e1 >= e2) || (b1 <= b2 && e1 >= b2) ||
                   (b1 >= b2 && e1 <= e2) || (b1 <= e2 && e1 >= e2);
  assign crossed = (ctrl.old_le && a1n >= a2n) || (ctrl.old_ge && a1n <= a2n);

  // away from zero: floor for negatives, ceiling for positives
  assign d = RND_W'(a1n) - RND_W'(a2n);
  assign r = d[RND_W-1] ? (d >>> FRAC_BITS) : ((d + RND_W'(BIAS)) >>> FRAC_BITS);

  assign upper = r[RND_W-1:sec_pkg::PUSH_W-1];
  assign fits  = (&upper) || !(|upper);
  assign sat   = fits ? r[sec_pkg::PUSH_W-1:0]
                      : (r[RND_W-1] ? sec_pkg::PUSH_MIN : sec_pkg::PUSH_MAX);

  assign delta  = (ctrl.active && overlap && crossed) ? sat : '0;
  assign push_x = ctrl.orient_y ? '0 : delta;
  assign push_y = ctrl.orient_y ? delta : '0;
endmodule

// ----- rtl/swept_edge_collision_unit.sv -----
// swept_edge_collision_unit: top level. Input word register, motion and
// resolve logic, result register. Depends on sec_pkg, sec_in_if, sec_out_if,
// sec_motion and sec_resolve.
//
// Swept collision test of two axis-aligned edges. Each input word carries
// both edges (orientation and direction flags, origin, velocity with
// FRAC_BITS fractional bits, length) and the elapsed step in ms; each word
// produces exactly one result word holding the penetration along the first
// edge's axis (push_x for an X edge, push_y for a Y edge, the other field
// zero), rounded away from zero to whole pixels and saturated to 20 bits.
// Mismatched orientations, edges not approaching per their flags, no extent
// overlap or no crossing during the step all give zero. Throughput is one
// word per clock while the result side is not stalled; an accepted word
// passes through the input register, then the result register. The path
// between the two registers holds one 16x11 multiply per swept coordinate
// followed by the adds, compares, rounding and saturation. in_ch.ready
// stays high while the result register is empty or being taken, so a
// stalled result holds at most one further word in the input register.
module swept_edge_collision_unit #(
  parameter int FRAC_BITS = sec_pkg::FRAC_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  sec_in_if.sink    in_ch,
  sec_out_if.source out_ch
);
  localparam int POS_W = sec_pkg::pos_width(FRAC_BITS);

  // input word stage
  logic               s1_valid_r, s1_valid_nxt;
  sec_pkg::sec_item_t s1_item_r;
  sec_pkg::sec_item_t in_item;

  // result stage
  logic                              out_valid_r, out_valid_nxt;
  logic signed [sec_pkg::PUSH_W-1:0] push_x_r, push_y_r;

  logic in_accept, out_load;

  sec_pkg::sec_ctrl_t      ctrl;
  logic signed [POS_W-1:0] a1n, a2n, b1, b2, e1, e2;
  logic signed [sec_pkg::PUSH_W-1:0] push_x_c, push_y_c;

  assign in_item.edge_flags      = in_ch.edge_flags;
  assign in_item.first_origin_x  = in_ch.first_origin_x;
  assign in_item.first_origin_y  = in_ch.first_origin_y;
  assign in_item.first_speed_x   = in_ch.first_speed_x;
  assign in_item.first_speed_y   = in_ch.first_speed_y;
  assign in_item.first_length    = in_ch.first_length;
  assign in_item.second_origin_x = in_ch.second_origin_x;
  assign in_item.second_origin_y = in_ch.second_origin_y;
  assign in_item.second_speed_x  = in_ch.second_speed_x;
  assign in_item.second_speed_y  = in_ch.second_speed_y;
  assign in_item.second_length   = in_ch.second_length;
  assign in_item.step_ms         = in_ch.step_ms;

  // word moves to the result register when that register is free or draining
  assign out_load    = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || out_load;
  assign in_accept   = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (out_load) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_item;
    end
    if (out_load) begin
      push_x_r <= push_x_c;
      push_y_r <= push_y_c;
    end
  end

  sec_motion #(.FRAC_BITS(FRAC_BITS)) u_motion (
    .item (s1_item_r),
    .ctrl (ctrl),
    .a1n  (a1n),
    .a2n  (a2n),
    .b1   (b1),
    .b2   (b2),
    .e1   (e1),
    .e2   (e2)
  );

  sec_resolve #(.FRAC_BITS(FRAC_BITS)) u_resolve (
    .ctrl   (ctrl),
    .a1n    (a1n),
    .a2n    (a2n),
    .b1     (b1),
    .b2     (b2),
    .e1     (e1),
    .e2     (e2),
    .push_x (push_x_c),
    .push_y (push_y_c)
  );

  assign out_ch.valid  = out_valid_r;
  assign out_ch.push_x = push_x_r;
  assign out_ch.push_y = push_y_r;

  // reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r))
    else $error("pipeline not empty after reset");

  // a held input word with a stalled result must block new input
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted over a stalled word");

  // a held word moves on when the result register is empty
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("word did not advance into empty result register");

  // only the first edge's axis carries a push
  a_one_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (push_x_r == '0 || push_y_r == '0))
    else $error("push on both axes");
endmodule

// ----- bench/tb.sv -----
// tb: self-checking bench for swept_edge_collision_unit. Streams edge-pair
// words over sec_in_if and checks each push word on sec_out_if.
// Depends on sec_pkg, sec_in_if, sec_out_if and the unit's RTL.
module tb;
  import sec_pkg::*;

  // one result word as the unit returns it
  typedef struct packed {
    logic signed [PUSH_W-1:0] push_x;
    logic signed [PUSH_W-1:0] push_y;
  } push_pair_t;

  // edge_flags bit masks
  localparam logic [FLAGS_W-1:0] F_Y1 = 6'(1) << FLG_ORIENT1;
  localparam logic [FLAGS_W-1:0] F_Y2 = 6'(1) << FLG_ORIENT2;
  localparam logic [FLAGS_W-1:0] F_P1 = 6'(1) << FLG_POS1;
  localparam logic [FLAGS_W-1:0] F_N1 = 6'(1) << FLG_NEG1;
  localparam logic [FLAGS_W-1:0] F_P2 = 6'(1) << FLG_POS2;
  localparam logic [FLAGS_W-1:0] F_N2 = 6'(1) << FLG_NEG2;
  localparam logic [FLAGS_W-1:0] F_YY = F_Y1 | F_Y2;

  logic clk;
  logic rst_n;

  sec_in_if  in_ch ();
  sec_out_if out_ch ();

  swept_edge_collision_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  push_pair_t expected_push_q[$];  // predictions, oldest first
  int mismatch_count = 0;
  int send_gap_max   = 0;          // sender idle cycles per word: 0..this
  int recv_stall_max = 0;          // receiver stall cycles per word: 0..this
  int stall_left     = 0;          // current per-word stall, set on accept
  int hold_left      = 0;          // long receiver hold-off, counted below

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Runaway guard, well past the slowest legal run.
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------
  // Predictor. Positions are kept exact in fixed point (FRAC_BITS
  // fraction bits) in 64-bit signed math, so nothing is lost before the
  // final round-away-from-zero.
  // --------------------------------------------------------------------
  function automatic push_pair_t predict_push(sec_item_t w);
    logic o1, o2, p1, n1, p2, n2, overlap, crossed;
    longint scale, ms, len1, len2, a1, a2, s1, s2, va1, va2, vs1, vs2;
    longint a1o, a2o, a1n, a2n, b1, b2, e1, e2, gap, pen;
    push_pair_t r;
    o1 = w.edge_flags[FLG_ORIENT1];
    o2 = w.edge_flags[FLG_ORIENT2];
    p1 = w.edge_flags[FLG_POS1];
    n1 = w.edge_flags[FLG_NEG1];
    p2 = w.edge_flags[FLG_POS2];
    n2 = w.edge_flags[FLG_NEG2];
    scale = longint'(1) << FRAC_BITS;
    ms    = longint'(w.step_ms);
    len1  = longint'(w.first_length);
    len2  = longint'(w.second_length);
    // a: axis the edge sits on and moves along; s: axis it spans
    a1  = o1 ? longint'($signed(w.first_origin_y))  : longint'($signed(w.first_origin_x));
    a2  = o1 ? longint'($signed(w.second_origin_y)) : longint'($signed(w.second_origin_x));
    s1  = o1 ? longint'($signed(w.first_origin_x))  : longint'($signed(w.first_origin_y));
    s2  = o1 ? longint'($signed(w.second_origin_x)) : longint'($signed(w.second_origin_y));
    va1 = o1 ? longint'($signed(w.first_speed_y))   : longint'($signed(w.first_speed_x));
    va2 = o1 ? longint'($signed(w.second_speed_y))  : longint'($signed(w.second_speed_x));
    vs1 = o1 ? longint'($signed(w.first_speed_x))   : longint'($signed(w.first_speed_y));
    vs2 = o1 ? longint'($signed(w.second_speed_x))  : longint'($signed(w.second_speed_y));
    pen = 0;
    if (o1 == o2 && ((p1 && n2 && va1 - va2 >= 0) || (n1 && p2 && va1 - va2 <= 0))) begin
      a1o = a1 * scale;
      a2o = a2 * scale;
      a1n = a1o + va1 * ms;
      a2n = a2o + va2 * ms;
      b1  = s1 * scale + vs1 * ms;
      b2  = s2 * scale + vs2 * ms;
      e1  = b1 + len1 * scale;
      e2  = b2 + len2 * scale;
      overlap = (b1 <= b2 && e1 >= e2) || (b1 <= b2 && e1 >= b2) ||
                (b1 >= b2 && e1 <= e2) || (b1 <= e2 && e1 >= e2);
      crossed = (a1o <= a2o && a1n >= a2n) || (a1o >= a2o && a1n <= a2n);
      if (overlap && crossed) begin
        gap = a1n - a2n;
        if (gap >= 0) pen = (gap + scale - 1) >>> FRAC_BITS;
        else pen = -((scale - 1 - gap) >>> FRAC_BITS);
      end
    end
    if (pen > PUSH_MAX) pen = PUSH_MAX;
    if (pen < PUSH_MIN) pen = PUSH_MIN;
    r.push_x = o1 ? '0 : pen[PUSH_W-1:0];
    r.push_y = o1 ? pen[PUSH_W-1:0] : '0;
    return r;
  endfunction

  // Places axis/span values on x or y depending on the first orientation.
  function automatic sec_item_t build_edge_pair(logic [FLAGS_W-1:0] flags,
                                                int a1, int a2, int va1, int va2,
                                                int s1, int s2, int vs1, int vs2,
                                                int len1, int len2, int ms);
    sec_item_t w;
    logic oy;
    oy = flags[FLG_ORIENT1];
    w.edge_flags      = flags;
    w.first_origin_x  = oy ? 16'(s1) : 16'(a1);
    w.first_origin_y  = oy ? 16'(a1) : 16'(s1);
    w.first_speed_x   = oy ? 16'(vs1) : 16'(va1);
    w.first_speed_y   = oy ? 16'(va1) : 16'(vs1);
    w.first_length    = 12'(len1);
    w.second_origin_x = oy ? 16'(s2) : 16'(a2);
    w.second_origin_y = oy ? 16'(a2) : 16'(s2);
    w.second_speed_x  = oy ? 16'(vs2) : 16'(va2);
    w.second_speed_y  = oy ? 16'(va2) : 16'(vs2);
    w.second_length   = 12'(len2);
    w.step_ms         = 10'(ms);
    return w;
  endfunction

  // Mostly approaching pairs whose gap is within reach of the step, so
  // the crossing and overlap logic gets real work; a quarter is raw noise.
  function automatic sec_item_t random_edge_pair();
    logic [191:0] raw;
    sec_item_t w;
    logic [FLAGS_W-1:0] flags;
    logic rising;
    int va1, va2, vs1, vs2, tmp, a1, a2, s1, s2, ms, reach, d, len1, len2;
    if ($urandom_range(0, 3) == 0) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      w = raw[$bits(sec_item_t)-1:0];
      if ($urandom_range(0, 1)) w.edge_flags[FLG_ORIENT2] = w.edge_flags[FLG_ORIENT1];
      return w;
    end
    flags  = $urandom_range(0, 1) ? F_YY : '0;
    rising = 1'($urandom_range(0, 1));
    ms  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 63);
    va1 = int'($signed(16'($urandom))) >>> $urandom_range(0, 8);
    va2 = int'($signed(16'($urandom))) >>> $urandom_range(0, 8);
    // rising: first sits below and closes upward (v >= 0); else mirrored
    if ((rising && va1 < va2) || (!rising && va1 > va2)) begin
      tmp = va1;
      va1 = va2;
      va2 = tmp;
    end
    flags |= rising ? (F_P1 | F_N2) : (F_N1 | F_P2);
    if ($urandom_range(0, 3) == 0) flags |= 6'($urandom_range(0, 15)) << FLG_POS1;
    reach = ((va1 > va2 ? va1 - va2 : va2 - va1) * ms) >>> FRAC_BITS;
    d  = $urandom_range(0, reach + reach / 8 + 2);
    a2 = int'($signed(16'($urandom)));
    a1 = rising ? a2 - d : a2 + d;
    s2 = int'($signed(16'($urandom)));
    s1 = s2 + int'($urandom_range(0, 600)) - 300;
    vs1 = $urandom_range(0, 1) ? 0 : int'($signed(16'($urandom))) >>> $urandom_range(4, 12);
    vs2 = $urandom_range(0, 1) ? 0 : int'($signed(16'($urandom))) >>> $urandom_range(4, 12);
    len1 = $urandom_range(0, 4095) >> $urandom_range(0, 11);
    len2 = $urandom_range(0, 4095) >> $urandom_range(0, 11);
    return build_edge_pair(flags, a1, a2, va1, va2, s1, s2, vs1, vs2, len1, len2, ms);
  endfunction

  // --------------------------------------------------------------------
  // Sender side. Inputs change on the falling edge only.
  // --------------------------------------------------------------------
  task automatic put_word(input sec_item_t w);
    in_ch.edge_flags      <= w.edge_flags;
    in_ch.first_origin_x  <= w.first_origin_x;
    in_ch.first_origin_y  <= w.first_origin_y;
    in_ch.first_speed_x   <= w.first_speed_x;
    in_ch.first_speed_y   <= w.first_speed_y;
    in_ch.first_length    <= w.first_length;
    in_ch.second_origin_x <= w.second_origin_x;
    in_ch.second_origin_y <= w.second_origin_y;
    in_ch.second_speed_x  <= w.second_speed_x;
    in_ch.second_speed_y  <= w.second_speed_y;
    in_ch.second_length   <= w.second_length;
    in_ch.step_ms         <= w.step_ms;
  endtask

  // Offers one word after a random idle gap; returns at the accepting
  // edge with the prediction queued. valid stays high into the next word
  // when the next gap is zero, so it never toggles within one step.
  task automatic offer_edge_pair(input sec_item_t w);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    put_word(w);
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    expected_push_q.push_back(predict_push(w));
  endtask

  // Sender goes quiet until every predicted word has come back.
  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (expected_push_q.size() == 0);
  endtask

  // --------------------------------------------------------------------
  // Receiver side: ready moves on the falling edge; a long hold-off
  // overrides the per-word stall.
  // --------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Result check on the rising edge: compare with the oldest prediction.
  always @(posedge clk) begin
    push_pair_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_push_q.size() == 0) begin
        $display("%0t: unexpected result word: expected none, got push_x %0d push_y %0d",
                 $time, out_ch.push_x, out_ch.push_y);
        mismatch_count++;
      end else begin
        want = expected_push_q.pop_front();
        if (out_ch.push_x !== want.push_x) begin
          $display("%0t: push_x mismatch: expected %0d, got %0d",
                   $time, want.push_x, out_ch.push_x);
          mismatch_count++;
        end
        if (out_ch.push_y !== want.push_y) begin
          $display("%0t: push_y mismatch: expected %0d, got %0d",
                   $time, want.push_y, out_ch.push_y);
          mismatch_count++;
        end
      end
      stall_left = $urandom_range(0, recv_stall_max);
    end
  end

  // --------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------

  // all-zero, all-ones, field minima/maxima and the largest sweeps
  task automatic test_field_extremes();
    send_gap_max   = 19;
    recv_stall_max = 19;
    offer_edge_pair('0);
    offer_edge_pair('1);
    offer_edge_pair(build_edge_pair(F_P1 | F_N2, -32768, -32768, -32768, -32768,
                                    -32768, -32768, -32768, -32768, 0, 0, 0));
    offer_edge_pair(build_edge_pair(F_YY | F_N1 | F_P2, 32767, 32767, 32767, 32767,
                                    32767, 32767, 32767, 32767, 4095, 4095, 1023));
    // full-range crossing along x, then the mirror along y
    offer_edge_pair(build_edge_pair(F_P1 | F_N2, -32768, 32767, 32767, -32768,
                                    0, 0, 0, 0, 4095, 4095, 1023));
    offer_edge_pair(build_edge_pair(F_YY | F_N1 | F_P2, 32767, -32768, -32768, 32767,
                                    0, 0, 0, 0, 4095, 4095, 1023));
  endtask

  // crossing geometry, but the edges of each pair lie on different axes
  task automatic test_orientation_mismatch();
    offer_edge_pair(build_edge_pair(F_Y1 | F_P1 | F_N2, 0, 10, 512, -512,
                                    0, 0, 0, 0, 50, 50, 10));
    offer_edge_pair(build_edge_pair(F_Y2 | F_P1 | F_N2, 0, 10, 512, -512,
                                    0, 0, 0, 0, 50, 50, 10));
  endtask

  // direction flags against the sign of the relative speed
  task automatic test_direction_flags();
    send_gap_max   = 0;
    recv_stall_max = 0;
    offer_edge_pair(build_edge_pair(F_P1 | F_N2, 0, 10, 512, -512, 0, 0, 0, 0, 50, 50, 10));
    offer_edge_pair(build_edge_pair(F_N1 | F_P2, 0, 10, 512, -512, 0, 0, 0, 0, 50, 50, 10));
    offer_edge_pair(build_edge_pair('0, 0, 10, 512, -512, 0, 0, 0, 0, 50, 50, 10));
    offer_edge_pair(build_edge_pair(F_P1, 0, 10, 512, -512, 0, 0, 0, 0, 50, 50, 10));
    offer_edge_pair(build_edge_pair(F_P1 | F_N1 | F_P2 | F_N2, 0, 10, 512, -512,
                                    0, 0, 0, 0, 50, 50, 10));
    offer_edge_pair(build_edge_pair(F_YY | F_N1 | F_P2, 10, 0, -512, 512,
                                    0, 0, 0, 0, 50, 50, 10));
    offer_edge_pair(build_edge_pair(F_P1 | F_N2, 10, 0, -512, 512, 0, 0, 0, 0, 50, 50, 10));
    // equal speeds and equal positions: crossing by equality, zero gap
    offer_edge_pair(build_edge_pair(F_YY | F_P1 | F_N2, 5, 5, 100, 100,
                                    0, 0, 0, 0, 20, 20, 7));
    offer_edge_pair(build_edge_pair(F_P1 | F_N2, 5, 5, 300, -300, 0, 0, 0, 0, 20, 20, 0));
  endtask

  // sub-pixel gaps round away from zero; exact pixels stay exact
  task automatic test_rounding();
    send_gap_max   = 19;
    recv_stall_max = 0;
    offer_edge_pair(build_edge_pair(F_P1 | F_N2, 0, 1, 300, 0, 0, 0, 0, 0, 8, 8, 1));
    offer_edge_pair(build_edge_pair(F_YY | F_N1 | F_P2, 1, 0, 0, 300, 0, 0, 0, 0, 8, 8, 1));
    offer_edge_pair(build_edge_pair(F_P1 | F_N2, 0, 1, 512, 0, 0, 0, 0, 0, 8, 8, 1));
  endtask

  // extent overlap: disjoint, touching, contained, swept into overlap,
  // plus a pair that never reaches the other edge
  task automatic test_span_overlap();
    send_gap_max   = 0;
    recv_stall_max = 19;
    offer_edge_pair(build_edge_pair(F_P1 | F_N2, 0, 10, 512, -512, 0, 20, 0, 0, 10, 5, 10));
    offer_edge_pair(build_edge_pair(F_YY | F_P1 | F_N2, 0, 10, 512, -512,
                                    0, 20, 0, 0, 20, 5, 10));
    offer_edge_pair(build_edge_pair(F_P1 | F_N2, 0, 10, 512, -512, 0, 10, 0, 0, 100, 5, 10));
    offer_edge_pair(build_edge_pair(F_P1 | F_N2, 0, 10, 512, -512, 0, 100, 0, -2560,
                                    5, 5, 10));
    offer_edge_pair(build_edge_pair(F_P1 | F_N2, 0, 100, 256, 0, 0, 0, 0, 0, 50, 50, 10));
  endtask

  // receiver holds off while the sender keeps offering back to back, so
  // both registers fill and input ready drops; then the sender drains
  task automatic test_backpressure();
    send_gap_max   = 0;
    recv_stall_max = 0;
    hold_left      = 300;
    repeat (20) offer_edge_pair(random_edge_pair());
    wait_for_results();
  endtask

  // random stream; idling on each side is drawn anew per block of 50 words so
  // there are stretches at full rate as well
  task automatic test_random_stream(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        send_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 19;
        recv_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
      end
      if (i == count / 2) wait_for_results();
      offer_edge_pair(random_edge_pair());
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    put_word('0);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_orientation_mismatch();
    test_direction_flags();
    test_rounding();
    test_span_overlap();
    test_backpressure();
    test_random_stream(1510);

    // drain, then give the two-stage pipe time to show any stray word
    wait_for_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sec_pkg.sv
rtl/sec_in_if.sv
rtl/sec_out_if.sv
rtl/sec_motion.sv
rtl/sec_resolve.sv
rtl/swept_edge_collision_unit.sv
bench/tb.sv
